/* sv/rlst_pkg.sv */
// Shared types, sizes and helpers for the ring log span tracker.
// No dependencies; every other file imports this package.
package rlst_pkg;

  localparam int SPAN_DEPTH = 16;
  localparam int LOG_BITS   = 20;
  localparam int COUNT_W    = 32;
  localparam int SLOT_W     = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;
  localparam int CNT_W      = $clog2(SPAN_DEPTH + 1);
  localparam int REQ_W      = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ROLLBACK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

  typedef struct packed {
    logic [LOG_BITS-1:0] start;
    logic [LOG_BITS-1:0] size;
  } span_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    span_t             wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic                ok;
    logic                overflowed;
    logic [LOG_BITS-1:0] span_start;
    logic [LOG_BITS-1:0] span_size;
    logic [LOG_BITS-1:0] next_start;
    logic [CNT_W-1:0]    spans_held;
  } result_t;

  // Circular slot arithmetic: base < SPAN_DEPTH, ofs <= SPAN_DEPTH
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(SPAN_DEPTH)) begin
      sum = sum - (CNT_W+1)'(SPAN_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

/* sv/ring_log_span_tracker_top.sv */
// Ring log span tracker: an item is taken when start is high and busy is low.
// Clear, overflowing or zero-size appends, unknown requests and rollbacks of an
// empty list strobe out_valid in the cycle after acceptance. A rollback reads
// the newest span from the RAM and returns it from S_ROLL. An append goes to
// S_PUSH when the list is empty, else to S_CHECK, which drops the oldest spans
// that overlap the new one until one does not or every span is dropped: the
// span RAM is read once per cycle while the front of the list is checked, then
// the new span is written in S_PUSH. busy is high until the cycle the result
// shows. Each result is on the out_ ports for exactly one cycle with out_valid
// high and cannot be held off. No clearing pass after reset.
// Depends on rlst_pkg, rlst_ctrl, rlst_span_ram.
module ring_log_span_tracker_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rlst_pkg::REQ_W-1:0]    in_req_type,
  input  logic [rlst_pkg::LOG_BITS-1:0] in_write_start,
  input  logic [rlst_pkg::COUNT_W-1:0]  in_write_count,
  input  logic                          cfg_we,
  input  logic [rlst_pkg::LOG_BITS-1:0] cfg_wdata,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic                          out_overflowed,
  output logic [rlst_pkg::LOG_BITS-1:0] out_span_start,
  output logic [rlst_pkg::LOG_BITS-1:0] out_span_size,
  output logic [rlst_pkg::LOG_BITS-1:0] out_next_start,
  output logic [rlst_pkg::CNT_W-1:0]    out_spans_held
);
  import rlst_pkg::*;

  logic [LOG_BITS-1:0] ring_mask_r;
  mem_req_t            mem_req;
  span_t               rd_data;
  result_t             result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_mask_r <= {LOG_BITS{1'b1}};
    end else if (cfg_we) begin
      ring_mask_r <= cfg_wdata;
    end
  end

  rlst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .req_type    (in_req_type),
    .write_start (in_write_start),
    .write_count (in_write_count),
    .ring_mask   (ring_mask_r),
    .mem_req     (mem_req),
    .rd_data     (rd_data),
    .result      (result)
  );

  rlst_span_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign out_valid      = result.valid;
  assign out_ok         = result.ok;
  assign out_overflowed = result.overflowed;
  assign out_span_start = result.span_start;
  assign out_span_size  = result.span_size;
  assign out_next_start = result.next_start;
  assign out_spans_held = result.spans_held;

endmodule

/* sv/rlst_span_ram.sv */
// Span store: one synchronous RAM of start/size pairs, one write and one read port.
// Read data is registered. Depends on rlst_pkg.
module rlst_span_ram (
  input  logic             clk,
  input  rlst_pkg::mem_req_t req,
  output rlst_pkg::span_t  rd_data
);
  import rlst_pkg::*;

  span_t mem [SPAN_DEPTH];
  span_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/rlst_collide.sv */
// Overlap test between a new span and a stored span on the circular log,
// covering the four wrap cases. Pure logic; depends on rlst_pkg.
module rlst_collide (
  input  logic [rlst_pkg::LOG_BITS-1:0] ring_mask,
  input  rlst_pkg::span_t               new_span,
  input  rlst_pkg::span_t               old_span,
  output logic                          hit
);
  import rlst_pkg::*;

  localparam int EW = LOG_BITS + 1;

  logic [EW-1:0] mask_e, shift;
  logic [EW-1:0] so, uo, eo, sc, uc, ec;
  logic          ow, cw;

  function automatic logic ovl(input logic [EW-1:0] sa, input logic [EW-1:0] ea,
                               input logic [EW-1:0] sb, input logic [EW-1:0] eb);
    logic [EW-1:0] lo, hi;
    lo = (sa > sb) ? sa : sb;
    hi = (ea < eb) ? ea : eb;
    return hi > lo;
  endfunction

  always_comb begin
    mask_e = EW'(ring_mask);
    shift  = mask_e + EW'(1);
    so = EW'(new_span.start);
    uo = so + EW'(new_span.size);
    eo = uo & mask_e;
    ow = uo > mask_e;
    sc = EW'(old_span.start);
    uc = sc + EW'(old_span.size);
    ec = uc & mask_e;
    cw = uc > mask_e;
    unique case ({ow, cw})
      2'b00:   hit = ovl(so, eo, sc, ec);
      2'b10:   hit = ovl(so, uo, sc, ec) || ovl(so, uo, sc + shift, ec + shift);
      2'b01:   hit = ovl(sc, uc, so, eo) || ovl(sc, uc, so + shift, eo + shift);
      default: hit = ovl(so, uo, sc, uc);
    endcase
  end

endmodule

/* sv/rlst_ctrl.sv */
// Sequencer: decodes requests, walks the oldest spans through the RAM,
// pushes and pops spans, and registers the result. Depends on rlst_pkg, rlst_collide.
module rlst_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rlst_pkg::REQ_W-1:0]    req_type,
  input  logic [rlst_pkg::LOG_BITS-1:0] write_start,
  input  logic [rlst_pkg::COUNT_W-1:0]  write_count,
  input  logic [rlst_pkg::LOG_BITS-1:0] ring_mask,
  output rlst_pkg::mem_req_t            mem_req,
  input  rlst_pkg::span_t               rd_data,
  output rlst_pkg::result_t             result
);
  import rlst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_PUSH, S_ROLL} state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  span_t             span_r, span_nxt;
  result_t           res_r, res_nxt;
  logic              hit;
  logic              accept;

  rlst_collide u_collide (
    .ring_mask (ring_mask),
    .new_span  (span_r),
    .old_span  (rd_data),
    .hit       (hit)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    span_nxt   = span_r;
    res_nxt    = res_r;
    res_nxt.valid = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = slot_add(oldest_r, count_r);
    mem_req.wdata = span_r;
    mem_req.raddr = oldest_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.ok         = 1'b0;
          res_nxt.overflowed = 1'b0;
          res_nxt.span_start = '0;
          res_nxt.span_size  = '0;
          res_nxt.next_start = '0;
          res_nxt.spans_held = count_r;
          unique case (req_type)
            REQ_APPEND: begin
              span_nxt.start = write_start;
              span_nxt.size  = write_count[LOG_BITS-1:0];
              if (write_count > COUNT_W'(ring_mask)) begin
                // overflow: history is gone
                count_nxt          = '0;
                oldest_nxt         = '0;
                res_nxt.valid      = 1'b1;
                res_nxt.ok         = 1'b1;
                res_nxt.overflowed = 1'b1;
                res_nxt.spans_held = '0;
              end else if (write_count == '0) begin
                res_nxt.valid      = 1'b1;
                res_nxt.ok         = 1'b1;
                res_nxt.next_start = write_start;
              end else if (count_r == '0) begin
                state_nxt = S_PUSH;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            REQ_ROLLBACK: begin
              if (count_r == '0) begin
                res_nxt.valid = 1'b1;
              end else begin
                mem_req.raddr = slot_add(oldest_r, count_r - CNT_W'(1));
                state_nxt     = S_ROLL;
              end
            end
            REQ_CLEAR: begin
              count_nxt          = '0;
              oldest_nxt         = '0;
              res_nxt.valid      = 1'b1;
              res_nxt.ok         = 1'b1;
              res_nxt.spans_held = '0;
            end
            default: begin
              res_nxt.valid = 1'b1;
            end
          endcase
        end
      end

      S_CHECK: begin
        // rd_data holds the oldest span; drop it while it overlaps
        if (hit) begin
          oldest_nxt = slot_add(oldest_r, CNT_W'(1));
          count_nxt  = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = S_PUSH;
          end
        end else begin
          state_nxt = S_PUSH;
        end
        mem_req.raddr = oldest_nxt;
      end

      S_PUSH: begin
        // when full the new span overwrites the oldest slot
        mem_req.we = 1'b1;
        if (count_r == CNT_W'(SPAN_DEPTH)) begin
          oldest_nxt = slot_add(oldest_r, CNT_W'(1));
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
        res_nxt.valid      = 1'b1;
        res_nxt.ok         = 1'b1;
        res_nxt.next_start = (span_r.start + span_r.size) & ring_mask;
        res_nxt.spans_held = count_nxt;
        state_nxt          = S_IDLE;
      end

      S_ROLL: begin
        count_nxt          = count_r - CNT_W'(1);
        res_nxt.valid      = 1'b1;
        res_nxt.ok         = 1'b1;
        res_nxt.span_start = rd_data.start;
        res_nxt.span_size  = rd_data.size;
        res_nxt.next_start = (count_nxt != '0) ? rd_data.start : '0;
        res_nxt.spans_held = count_nxt;
        state_nxt          = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oldest_r <= '0;
      count_r  <= '0;
      span_r   <= '0;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      span_r   <= span_nxt;
      res_r    <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

/* sv/rlst_checker.sv */
// Port-level checks for the ring log span tracker, bound to the top level.
// Depends on rlst_pkg and ring_log_span_tracker_top.
module rlst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [rlst_pkg::REQ_W-1:0]    in_req_type,
  input logic                          out_valid,
  input logic                          out_ok,
  input logic                          out_overflowed,
  input logic [rlst_pkg::LOG_BITS-1:0] out_span_start,
  input logic [rlst_pkg::LOG_BITS-1:0] out_span_size,
  input logic [rlst_pkg::LOG_BITS-1:0] out_next_start,
  input logic [rlst_pkg::CNT_W-1:0]    out_spans_held
);
  import rlst_pkg::*;

  // clear gives its result in the next cycle and empties the list
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_CLEAR |=>
      out_valid && out_ok && out_spans_held == '0 && out_next_start == '0)
    else $error("clear item did not give an empty result");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_spans_held <= CNT_W'(SPAN_DEPTH))
    else $error("spans_held above list depth");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |->
      out_ok && out_spans_held == '0 && out_next_start == '0)
    else $error("overflow result left spans behind");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |->
      out_span_start == '0 && out_span_size == '0 && out_next_start == '0)
    else $error("failed item carried values");

endmodule

bind ring_log_span_tracker_top rlst_checker u_rlst_checker (.*);
